// ===== rtl/prdg_pkg.sv =====
// Shared widths, register codes, reset values and helpers of the primary ray
// direction generator. No dependencies.
`default_nettype none

package prdg_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int COEF_BITS  = 16;
    localparam int DIR_BITS   = 16;
    localparam int LANE_BITS  = 16;
    localparam int ROW_BITS   = 64;
    localparam int IMG_BITS   = 24;

    localparam int COEF_FRAC = COEF_BITS - 4;
    localparam int DIR_FRAC  = DIR_BITS - 2;
    localparam int NDC_FRAC  = 16;

    localparam int NDC_MAG_W = PIXEL_BITS + 1 + NDC_FRAC;
    localparam int U_W       = NDC_MAG_W + 1;
    localparam int PROD_W    = COEF_BITS + U_W;
    localparam int KSUM_W    = COEF_BITS + 1;
    localparam int T_W       = PROD_W + 2;
    localparam int MAG_W     = T_W - 1;
    localparam int POS_W     = $clog2(MAG_W);

    localparam int A_W      = 30;
    localparam int NORM_POS = A_W - 1;
    localparam int SQ_W     = 2 * A_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int LEN_W    = SUM_W / 2;
    localparam int SQRT_W   = SUM_W + 1;

    localparam int DIV_NUM_W = A_W + DIR_FRAC + 1;
    localparam int DIV_DEN_W = LEN_W;
    localparam int DIV_Q_W   = NDC_MAG_W;
    localparam int DIV_CMP_W = DIV_DEN_W + DIV_Q_W;

    localparam int VPROD_W = COEF_BITS + DIR_BITS;
    localparam int VSUM_W  = VPROD_W + 2;
    localparam int RND_W   = VSUM_W + 1;
    localparam int DIR_ONE = 1 << DIR_FRAC;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_ROW0  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_ROW1  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_ROW2  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_ROW3  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ROW0  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ROW1  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ROW2  = 4'd7;

    localparam logic [IMG_BITS-1:0] IMAGE_SIZE_RST = 24'd4097;
    localparam logic [ROW_BITS-1:0] ROW0_RST = 64'd4096;
    localparam logic [ROW_BITS-1:0] ROW1_RST = 64'd268435456;
    localparam logic [ROW_BITS-1:0] ROW2_RST = 64'd17592186044416;
    localparam logic [ROW_BITS-1:0] ROW3_RST = 64'd1152921504606846976;

    function automatic logic signed [COEF_BITS-1:0] coef_lane(
        input logic [ROW_BITS-1:0] row,
        input int unsigned         idx
    );
        return $signed(row[LANE_BITS*idx +: COEF_BITS]);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/prdg_pixel_if.sv =====
// Pixel coordinate channel: valid, ready and one pixel per beat.
// Depends on prdg_pkg.
`default_nettype none

interface prdg_pixel_if
    import prdg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/prdg_dir_if.sv =====
// Ray direction channel: valid, ready and one direction per beat.
// Depends on prdg_pkg.
`default_nettype none

interface prdg_dir_if
    import prdg_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [DIR_BITS-1:0] dir_x;
    logic signed [DIR_BITS-1:0] dir_y;
    logic signed [DIR_BITS-1:0] dir_z;
    logic                       degenerate;

    modport source (output valid, output dir_x, output dir_y, output dir_z,
                    output degenerate, input ready);
    modport sink (input valid, input dir_x, input dir_y, input dir_z,
                  input degenerate, output ready);
endinterface

`default_nettype wire

// ===== rtl/prdg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on prdg_pkg.
`default_nettype none

module prdg_div
    import prdg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic      [DIV_Q_W-1:0]   quo,
    output logic                      rem_nz
);

    logic [DIV_CMP_W-1:0] rem_reg [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0]   quo_reg [DIV_Q_W];

    for (genvar g = 0; g < DIV_Q_W; g++)
    begin : g_stage
        localparam int BIT = DIV_Q_W - 1 - g;
        logic [DIV_CMP_W-1:0] rem_in;
        logic [DIV_CMP_W-1:0] dvs;
        logic [DIV_CMP_W-1:0] rem_next;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_Q_W-1:0]   quo_in;
        logic [DIV_Q_W-1:0]   quo_next;

        if (g == 0)
        begin : g_first
            assign rem_in = DIV_CMP_W'(num);
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        assign dvs = DIV_CMP_W'(den_in) << BIT;

        always_comb
        begin
            if (rem_in >= dvs)
            begin
                rem_next = rem_in - dvs;
                quo_next = quo_in | (DIV_Q_W'(1) << BIT);
            end
            else
            begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                den_reg[g] <= den_in;
                quo_reg[g] <= quo_next;
            end
        end
    end

    assign quo    = quo_reg[DIV_Q_W-1];
    assign rem_nz = |rem_reg[DIV_Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/prdg_sqrt.sv =====
// Pipelined floor integer square root, one root bit per stage.
// Depends on prdg_pkg.
`default_nettype none

module prdg_sqrt
    import prdg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [SUM_W-1:0] rad,
    output logic      [LEN_W-1:0] root
);

    logic [SQRT_W-1:0] rem_reg [LEN_W];
    logic [LEN_W-1:0]  root_reg [LEN_W];

    for (genvar g = 0; g < LEN_W; g++)
    begin : g_stage
        localparam int BIT = LEN_W - 1 - g;
        logic [SQRT_W-1:0] rem_in;
        logic [SQRT_W-1:0] trial;
        logic [SQRT_W-1:0] rem_next;
        logic [LEN_W-1:0]  root_in;
        logic [LEN_W-1:0]  root_next;

        if (g == 0)
        begin : g_first
            assign rem_in  = SQRT_W'(rad);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        assign trial = (SQRT_W'(root_in) << (BIT + 1)) + (SQRT_W'(1) << (2 * BIT));

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (LEN_W'(1) << BIT);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
            end
        end
    end

    assign root = root_reg[LEN_W-1];

endmodule

`default_nettype wire

// ===== rtl/primary_ray_direction_generator_top.sv =====
// Primary ray direction generator top level: configuration registers and the
// full ray pipeline. Depends on prdg_pkg, prdg_pixel_if, prdg_dir_if,
// prdg_div and prdg_sqrt.
//
// Usage:
//   pix carries one pixel coordinate per beat, dir returns one world-space
//   unit direction (Q1.14) per beat, in order, with degenerate set when the
//   projected w is zero.
//   The configuration port writes image size, inverse projection rows and
//   inverse view rows by index; write only while no pixel is in flight.
//   Throughput is one pixel per cycle while dir is not stalled; the pipeline
//   holds up to 104 pixels, most of them in the 29-stage NDC and normalizing
//   dividers and in the 31-stage square root.
//   Reset clears all valid bits and loads identity matrices and a 1x1 image.
//   When the receiver stalls with a beat waiting, the whole pipeline holds
//   and pix.ready drops; nothing is lost or repeated.
`default_nettype none

module primary_ray_direction_generator_top
    import prdg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    prdg_pixel_if.sink                 pix,
    prdg_dir_if.source                 dir
);

    typedef struct packed {
        logic negx;
        logic negy;
    } ndc_tag_t;

    typedef struct packed {
        logic                   deg;
        logic                   zero;
        logic [2:0]             neg;
        logic [2:0][A_W-1:0]    a;
    } sq_tag_t;

    typedef struct packed {
        logic       deg;
        logic       zero;
        logic [2:0] neg;
    } nd_tag_t;

    logic [IMG_BITS-1:0] image_size_reg;
    logic [ROW_BITS-1:0] proj_reg [4];
    logic [ROW_BITS-1:0] view_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= IMAGE_SIZE_RST;
            proj_reg[0]    <= ROW0_RST;
            proj_reg[1]    <= ROW1_RST;
            proj_reg[2]    <= ROW2_RST;
            proj_reg[3]    <= ROW3_RST;
            view_reg[0]    <= ROW0_RST;
            view_reg[1]    <= ROW1_RST;
            view_reg[2]    <= ROW2_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_SIZE: image_size_reg <= cfg_wdata[IMG_BITS-1:0];
                CFG_PROJ_ROW0:  proj_reg[0] <= cfg_wdata;
                CFG_PROJ_ROW1:  proj_reg[1] <= cfg_wdata;
                CFG_PROJ_ROW2:  proj_reg[2] <= cfg_wdata;
                CFG_PROJ_ROW3:  proj_reg[3] <= cfg_wdata;
                CFG_VIEW_ROW0:  view_reg[0] <= cfg_wdata;
                CFG_VIEW_ROW1:  view_reg[1] <= cfg_wdata;
                CFG_VIEW_ROW2:  view_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic dir_valid_reg;

    assign en        = !dir_valid_reg || dir.ready;
    assign pix.ready = en;

    // NDC numerators
    logic [PIXEL_BITS-1:0]          wd;
    logic [PIXEL_BITS-1:0]          ht;
    logic signed [PIXEL_BITS+1:0]   dx;
    logic signed [PIXEL_BITS+1:0]   dy;
    logic [PIXEL_BITS:0]            magx;
    logic [PIXEL_BITS:0]            magy;
    logic                           a_valid_reg;
    logic [NDC_MAG_W-1:0]           nx_reg;
    logic [NDC_MAG_W-1:0]           ny_reg;
    ndc_tag_t                       a_tag_reg;

    always_comb
    begin
        wd = image_size_reg[PIXEL_BITS-1:0];
        ht = image_size_reg[2*PIXEL_BITS-1:PIXEL_BITS];
        if (wd == '0)
        begin
            wd = PIXEL_BITS'(1);
        end
        if (ht == '0)
        begin
            ht = PIXEL_BITS'(1);
        end
        dx   = $signed({1'b0, pix.pixel_x, 1'b0}) - $signed({2'b00, wd});
        dy   = $signed({1'b0, pix.pixel_y, 1'b0}) - $signed({2'b00, ht});
        magx = dx[PIXEL_BITS+1] ? (PIXEL_BITS+1)'(-dx) : (PIXEL_BITS+1)'(dx);
        magy = dy[PIXEL_BITS+1] ? (PIXEL_BITS+1)'(-dy) : (PIXEL_BITS+1)'(dy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg         <= {magx, NDC_FRAC'(0)};
            ny_reg         <= {magy, NDC_FRAC'(0)};
            a_tag_reg.negx <= dx[PIXEL_BITS+1];
            a_tag_reg.negy <= dy[PIXEL_BITS+1];
        end
    end

    logic [DIV_Q_W-1:0] qx;
    logic [DIV_Q_W-1:0] qy;
    logic               rx_nz;
    logic               ry_nz;

    prdg_div u_div_x (
        .clk    (clk),
        .en     (en),
        .num    (DIV_NUM_W'(nx_reg)),
        .den    (DIV_DEN_W'(wd)),
        .quo    (qx),
        .rem_nz (rx_nz)
    );

    prdg_div u_div_y (
        .clk    (clk),
        .en     (en),
        .num    (DIV_NUM_W'(ny_reg)),
        .den    (DIV_DEN_W'(ht)),
        .quo    (qy),
        .rem_nz (ry_nz)
    );

    logic [DIV_Q_W-1:0] ndc_vld_reg;
    ndc_tag_t           ndc_tag_reg [DIV_Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ndc_tag_reg[0] <= a_tag_reg;
            for (int i = 1; i < DIV_Q_W; i++)
            begin
                ndc_tag_reg[i] <= ndc_tag_reg[i-1];
            end
        end
    end

    // u, v and projection
    logic                     b_valid_reg;
    logic signed [U_W-1:0]    u_reg;
    logic signed [U_W-1:0]    v_reg;
    logic                     c_valid_reg;
    logic signed [PROD_W-1:0] p0_reg [4];
    logic signed [PROD_W-1:0] p1_reg [4];
    logic signed [KSUM_W-1:0] k_reg [4];
    logic                     d_valid_reg;
    logic signed [T_W-1:0]    t_reg [4];
    ndc_tag_t                 ndc_out;

    assign ndc_out = ndc_tag_reg[DIV_Q_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= ndc_out.negx ? -(U_W'(qx) + U_W'(rx_nz)) : U_W'(qx);
            v_reg <= ndc_out.negy ? -(U_W'(qy) + U_W'(ry_nz)) : U_W'(qy);
            for (int r = 0; r < 4; r++)
            begin
                p0_reg[r] <= PROD_W'(coef_lane(proj_reg[r], 0)) * PROD_W'(u_reg);
                p1_reg[r] <= PROD_W'(coef_lane(proj_reg[r], 1)) * PROD_W'(v_reg);
                k_reg[r]  <= KSUM_W'(coef_lane(proj_reg[r], 2))
                           + KSUM_W'(coef_lane(proj_reg[r], 3));
                t_reg[r]  <= T_W'(p0_reg[r]) + T_W'(p1_reg[r])
                           + (T_W'(k_reg[r]) <<< NDC_FRAC);
            end
        end
    end

    // magnitudes, normalizing shift
    logic                  e_valid_reg;
    logic [MAG_W-1:0]      ea_reg [3];
    logic [2:0]            e_neg_reg;
    logic                  e_deg_reg;
    logic                  f_valid_reg;
    logic [MAG_W-1:0]      fa_reg [3];
    logic [MAG_W-1:0]      fm_reg;
    logic [2:0]            f_neg_reg;
    logic                  f_deg_reg;
    logic                  g_valid_reg;
    logic [MAG_W-1:0]      ga_reg [3];
    logic [POS_W-1:0]      g_pos_reg;
    logic                  g_zero_reg;
    logic [2:0]            g_neg_reg;
    logic                  g_deg_reg;
    logic [MAG_W-1:0]      m01;
    logic [MAG_W-1:0]      m_next;
    logic [POS_W-1:0]      pos_next;

    always_comb
    begin
        m01      = (ea_reg[0] > ea_reg[1]) ? ea_reg[0] : ea_reg[1];
        m_next   = (ea_reg[2] > m01) ? ea_reg[2] : m01;
        pos_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (fm_reg[i])
            begin
                pos_next = POS_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_deg_reg <= (t_reg[3] == '0);
            for (int i = 0; i < 3; i++)
            begin
                ea_reg[i]    <= t_reg[i][T_W-1] ? MAG_W'(-t_reg[i]) : MAG_W'(t_reg[i]);
                e_neg_reg[i] <= t_reg[i][T_W-1] ^ t_reg[3][T_W-1];
                fa_reg[i]    <= ea_reg[i];
                ga_reg[i]    <= fa_reg[i];
            end
            fm_reg     <= m_next;
            f_neg_reg  <= e_neg_reg;
            f_deg_reg  <= e_deg_reg;
            g_pos_reg  <= pos_next;
            g_zero_reg <= (fm_reg == '0);
            g_neg_reg  <= f_neg_reg;
            g_deg_reg  <= f_deg_reg;
        end
    end

    logic                  h_valid_reg;
    sq_tag_t               h_tag_reg;
    logic                  i_valid_reg;
    sq_tag_t               i_tag_reg;
    logic [SQ_W-1:0]       sq_reg [3];
    logic                  j_valid_reg;
    sq_tag_t               j_tag_reg;
    logic [SUM_W-1:0]      s_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_tag_reg.deg  <= g_deg_reg;
            h_tag_reg.zero <= g_zero_reg;
            h_tag_reg.neg  <= g_neg_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (g_pos_reg >= POS_W'(NORM_POS))
                begin
                    h_tag_reg.a[i] <= A_W'(ga_reg[i] >> (g_pos_reg - POS_W'(NORM_POS)));
                end
                else
                begin
                    h_tag_reg.a[i] <= A_W'(ga_reg[i] << (POS_W'(NORM_POS) - g_pos_reg));
                end
                sq_reg[i] <= SQ_W'(h_tag_reg.a[i]) * SQ_W'(h_tag_reg.a[i]);
            end
            i_tag_reg <= h_tag_reg;
            j_tag_reg <= i_tag_reg;
            s_reg     <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        end
    end

    // length
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] sq_vld_reg;
    sq_tag_t          sq_tag_reg [LEN_W];

    prdg_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (s_reg),
        .root (len)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_tag_reg[0] <= j_tag_reg;
            for (int i = 1; i < LEN_W; i++)
            begin
                sq_tag_reg[i] <= sq_tag_reg[i-1];
            end
        end
    end

    // unit vector
    logic                 k_valid_reg;
    logic [DIV_NUM_W-1:0] kn_reg [3];
    logic [DIV_DEN_W-1:0] kd_reg;
    nd_tag_t              k_tag_reg;
    sq_tag_t              sq_out;

    assign sq_out = sq_tag_reg[LEN_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                kn_reg[i] <= (DIV_NUM_W'(sq_out.a[i]) << DIR_FRAC)
                           + DIV_NUM_W'(len >> 1);
            end
            kd_reg         <= DIV_DEN_W'(len);
            k_tag_reg.deg  <= sq_out.deg;
            k_tag_reg.zero <= sq_out.zero;
            k_tag_reg.neg  <= sq_out.neg;
        end
    end

    logic [DIV_Q_W-1:0] cq [3];
    logic [2:0]         cq_nz;

    for (genvar c = 0; c < 3; c++)
    begin : g_norm
        prdg_div u_div_n (
            .clk    (clk),
            .en     (en),
            .num    (kn_reg[c]),
            .den    (kd_reg),
            .quo    (cq[c]),
            .rem_nz (cq_nz[c])
        );
    end

    logic [DIV_Q_W-1:0] nd_vld_reg;
    nd_tag_t            nd_tag_reg [DIV_Q_W];
    nd_tag_t            nd_out;

    assign nd_out = nd_tag_reg[DIV_Q_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_tag_reg[0] <= k_tag_reg;
            for (int i = 1; i < DIV_Q_W; i++)
            begin
                nd_tag_reg[i] <= nd_tag_reg[i-1];
            end
        end
    end

    // view rotation
    logic                      l_valid_reg;
    logic signed [DIR_BITS-1:0] n_reg [3];
    logic [1:0]                l_flag_reg;
    logic                      m_valid_reg;
    logic signed [VPROD_W-1:0] vp_reg [3][3];
    logic [1:0]                m_flag_reg;
    logic                      n_valid_reg;
    logic signed [VSUM_W-1:0]  vd_reg [3];
    logic [1:0]                n_flag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= nd_out.neg[i] ? -DIR_BITS'(cq[i][DIR_FRAC:0])
                                          : DIR_BITS'(cq[i][DIR_FRAC:0]);
            end
            l_flag_reg <= {nd_out.deg, nd_out.zero | (&cq_nz & 1'b0)};
            for (int j = 0; j < 3; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vp_reg[j][i] <= VPROD_W'(coef_lane(view_reg[j], i)) * VPROD_W'(n_reg[i]);
                end
                vd_reg[j] <= VSUM_W'(vp_reg[j][0]) + VSUM_W'(vp_reg[j][1])
                           + VSUM_W'(vp_reg[j][2]);
            end
            m_flag_reg <= l_flag_reg;
            n_flag_reg <= m_flag_reg;
        end
    end

    // round, saturate, output register
    logic [VSUM_W-1:0]          dm [3];
    logic [RND_W-1:0]           rs [3];
    logic [RND_W-1:0]           rq [3];
    logic [DIR_BITS-1:0]        sat [3];
    logic signed [DIR_BITS-1:0] dir_next [3];
    logic signed [DIR_BITS-1:0] dir_reg [3];
    logic                       deg_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dm[j]  = vd_reg[j][VSUM_W-1] ? VSUM_W'(-vd_reg[j]) : VSUM_W'(vd_reg[j]);
            rs[j]  = RND_W'(dm[j]) + (RND_W'(1) << (COEF_FRAC - 1));
            rq[j]  = rs[j] >> COEF_FRAC;
            sat[j] = (rq[j] > RND_W'(DIR_ONE)) ? DIR_BITS'(DIR_ONE) : DIR_BITS'(rq[j]);
            if (n_flag_reg != 2'b00)
            begin
                dir_next[j] = '0;
            end
            else
            begin
                dir_next[j] = vd_reg[j][VSUM_W-1] ? -$signed(sat[j]) : $signed(sat[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dir_reg[j] <= dir_next[j];
            end
            deg_reg <= n_flag_reg[1];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            ndc_vld_reg   <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            j_valid_reg   <= 1'b0;
            sq_vld_reg    <= '0;
            k_valid_reg   <= 1'b0;
            nd_vld_reg    <= '0;
            l_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            n_valid_reg   <= 1'b0;
            dir_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= pix.valid;
            ndc_vld_reg   <= {ndc_vld_reg[DIV_Q_W-2:0], a_valid_reg};
            b_valid_reg   <= ndc_vld_reg[DIV_Q_W-1];
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= f_valid_reg;
            h_valid_reg   <= g_valid_reg;
            i_valid_reg   <= h_valid_reg;
            j_valid_reg   <= i_valid_reg;
            sq_vld_reg    <= {sq_vld_reg[LEN_W-2:0], j_valid_reg};
            k_valid_reg   <= sq_vld_reg[LEN_W-1];
            nd_vld_reg    <= {nd_vld_reg[DIV_Q_W-2:0], k_valid_reg};
            l_valid_reg   <= nd_vld_reg[DIV_Q_W-1];
            m_valid_reg   <= l_valid_reg;
            n_valid_reg   <= m_valid_reg;
            dir_valid_reg <= n_valid_reg;
        end
    end

    assign dir.valid      = dir_valid_reg;
    assign dir.dir_x      = dir_reg[0];
    assign dir.dir_y      = dir_reg[1];
    assign dir.dir_z      = dir_reg[2];
    assign dir.degenerate = deg_reg;

endmodule

`default_nettype wire
